FILE: rtl/core/pip_pkg.sv
package pip_pkg;

  // Default coordinate width and queue depths
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned EDGE_Q_DEPTH   = 4;
  localparam int unsigned RES_Q_DEPTH    = 2;

  // Coordinate slots in a vertex record, counted from the LSB, COORD_BITS each
  localparam int unsigned REC_FX     = 0;
  localparam int unsigned REC_FY     = 1;
  localparam int unsigned REC_PX     = 2;
  localparam int unsigned REC_PY     = 3;
  localparam int unsigned REC_VX     = 4;
  localparam int unsigned REC_VY     = 5;
  localparam int unsigned REC_QX     = 6;
  localparam int unsigned REC_QY     = 7;
  localparam int unsigned REC_COORDS = 8;
  localparam int unsigned REC_FLAGS  = 2;

  // Flags that travel at the top of each vertex record
  typedef struct packed {
    logic first;  // opens a polygon: no edge to a previous vertex, parity restarts
    logic last;   // closes a polygon: test closing edge, emit a result
  } rec_flags_t;

endpackage

FILE: rtl/core/pip_queue.sv
module pip_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o    = (count_q == CntFull);
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("item pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("item popped from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count beyond depth");

endmodule

FILE: rtl/core/pip_front.sv
module pip_front #(
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic [COORD_BITS-1:0]                 query_x_i,
  input  logic [COORD_BITS-1:0]                 query_y_i,
  input  logic [COORD_BITS-1:0]                 vertex_x_i,
  input  logic [COORD_BITS-1:0]                 vertex_y_i,
  input  logic                                  last_vertex_i,
  output logic [pip_pkg::REC_COORDS*COORD_BITS+pip_pkg::REC_FLAGS-1:0] rec_o
);
  import pip_pkg::*;

  logic                  mid_q, mid_d;
  logic [COORD_BITS-1:0] qx_q, qy_q, fx_q, fy_q, px_q, py_q;
  logic [COORD_BITS-1:0] qx, qy, fx, fy;
  rec_flags_t            flags;

  // On a polygon's first vertex the query and first vertex come straight from the item
  always_comb begin
    flags.first = !mid_q;
    flags.last  = last_vertex_i;
    qx = mid_q ? qx_q : query_x_i;
    qy = mid_q ? qy_q : query_y_i;
    fx = mid_q ? fx_q : vertex_x_i;
    fy = mid_q ? fy_q : vertex_y_i;
    mid_d = accept_i ? !last_vertex_i : mid_q;
  end

  assign rec_o = {flags, qy, qx, vertex_y_i, vertex_x_i, py_q, px_q, fy, fx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else begin
      mid_q <= mid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      qx_q <= qx;
      qy_q <= qy;
      fx_q <= fx;
      fy_q <= fy;
      px_q <= vertex_x_i;
      py_q <= vertex_y_i;
    end
  end

endmodule

FILE: rtl/core/pip_back.sv
module pip_back #(
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [pip_pkg::REC_COORDS*COORD_BITS+pip_pkg::REC_FLAGS-1:0] rec_i,
  input  logic                                  rec_valid_i,
  output logic                                  rec_pop_o,
  input  logic                                  res_full_i,
  output logic                                  res_push_o,
  output logic                                  res_data_o
);
  import pip_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned RW = REC_COORDS * COORD_BITS + REC_FLAGS;

  function automatic logic signed [DW-1:0] dif(input logic [COORD_BITS-1:0] a,
                                              input logic [COORD_BITS-1:0] b);
    return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  rec_flags_t                   flags;
  logic signed [COORD_BITS-1:0] qx, qy, vx, vy, px, py, fx, fy;
  logic signed [DW-1:0]         a_dy, b_dy;
  logic signed [PW-1:0]         a_l_d, a_r_d, b_l_d, b_r_d;
  logic                         a_en_d, b_en_d;

  logic                         s1_valid_q, s1_valid_d;
  logic                         s1_first_q, s1_last_q;
  logic                         a_en_q, a_dpos_q, b_en_q, b_dpos_q;
  logic signed [PW-1:0]         a_l_q, a_r_q, b_l_q, b_r_q;
  logic                         parity_q, parity_d;
  logic                         a_cross, b_cross, par_next, adv;

  // Stage 0: unpack, straddle tests, cross products.
  // Edge A runs from this vertex to the previous one, edge B from the first to this one.
  always_comb begin
    flags = rec_flags_t'(rec_i[RW-1 -: REC_FLAGS]);
    qx = rec_i[REC_QX*COORD_BITS +: COORD_BITS];
    qy = rec_i[REC_QY*COORD_BITS +: COORD_BITS];
    vx = rec_i[REC_VX*COORD_BITS +: COORD_BITS];
    vy = rec_i[REC_VY*COORD_BITS +: COORD_BITS];
    px = rec_i[REC_PX*COORD_BITS +: COORD_BITS];
    py = rec_i[REC_PY*COORD_BITS +: COORD_BITS];
    fx = rec_i[REC_FX*COORD_BITS +: COORD_BITS];
    fy = rec_i[REC_FY*COORD_BITS +: COORD_BITS];
    a_dy   = dif(py, vy);
    b_dy   = dif(vy, fy);
    a_l_d  = dif(qx, vx) * a_dy;
    a_r_d  = dif(px, vx) * dif(qy, vy);
    b_l_d  = dif(qx, fx) * b_dy;
    b_r_d  = dif(vx, fx) * dif(qy, fy);
    a_en_d = !flags.first && ((vy > qy) != (py > qy));
    b_en_d = flags.last && ((fy > qy) != (vy > qy));
  end

  // Stage 1: compare, toggle parity. A straddling edge never has zero dy.
  always_comb begin
    a_cross  = a_en_q && (a_dpos_q ? (a_l_q < a_r_q) : (a_l_q > a_r_q));
    b_cross  = b_en_q && (b_dpos_q ? (b_l_q < b_r_q) : (b_l_q > b_r_q));
    par_next = (s1_first_q ? 1'b0 : parity_q) ^ a_cross ^ b_cross;
    adv      = s1_valid_q && (!s1_last_q || !res_full_i);
    rec_pop_o = rec_valid_i && (!s1_valid_q || adv);
    priority if (rec_pop_o) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    parity_d   = adv ? par_next : parity_q;
    res_push_o = adv && s1_last_q;
    res_data_o = par_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      parity_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      parity_q   <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      s1_first_q <= flags.first;
      s1_last_q  <= flags.last;
      a_en_q     <= a_en_d;
      b_en_q     <= b_en_d;
      a_dpos_q   <= !a_dy[DW-1];
      b_dpos_q   <= !b_dy[DW-1];
      a_l_q      <= a_l_d;
      a_r_q      <= a_r_d;
      b_l_q      <= b_l_d;
      b_r_q      <= b_r_d;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_last_q)))
    else $error("stalled item lost from back stage");

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o |-> rec_valid_i)
    else $error("vertex record taken while none waiting");

endmodule

FILE: rtl/core/point_in_polygon_test.sv
// Channel  | Direction | Handshake                 | Payload
// vertex   | in        | push / full               | query_x_i, query_y_i, vertex_x_i,
//          |           |                           | vertex_y_i, last_vertex_i
// result   | out       | pop / empty               | inside_res_o
//
// One vertex item per cycle sustained; full only rises when the result side stalls.
// From accept to result visible, an item is registered in the vertex queue, the stage-1 registers and the result queue.
// A result is given only for an item marked last_vertex; others produce nothing.
// Reset (rst_ni low) empties both queues and waits for a polygon's first vertex.
// The front and back are parted by a small vertex queue, so either side may stall alone.
module point_in_polygon_test #(
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int unsigned EDGE_DEPTH = pip_pkg::EDGE_Q_DEPTH,
  parameter int unsigned RES_DEPTH  = pip_pkg::RES_Q_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] query_x_i,
  input  logic [COORD_BITS-1:0] query_y_i,
  input  logic [COORD_BITS-1:0] vertex_x_i,
  input  logic [COORD_BITS-1:0] vertex_y_i,
  input  logic                  last_vertex_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  inside_res_o
);
  import pip_pkg::*;

  localparam int unsigned RW = REC_COORDS * COORD_BITS + REC_FLAGS;

  logic          accept;
  logic [RW-1:0] front_rec, back_rec;
  logic          rec_empty, rec_pop;
  logic          res_full, res_push, res_data;

  assign accept = push && !full;

  pip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .query_x_i,
    .query_y_i,
    .vertex_x_i,
    .vertex_y_i,
    .last_vertex_i,
    .rec_o         (front_rec)
  );

  pip_queue #(.WIDTH(RW), .DEPTH(EDGE_DEPTH)) u_rec_queue (
    .clk_i,
    .rst_ni,
    .push_i    (accept),
    .wr_data_i (front_rec),
    .full_o    (full),
    .pop_i     (rec_pop),
    .rd_data_o (back_rec),
    .empty_o   (rec_empty)
  );

  pip_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .rec_i       (back_rec),
    .rec_valid_i (!rec_empty),
    .rec_pop_o   (rec_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  pip_queue #(.WIDTH(1), .DEPTH(RES_DEPTH)) u_res_queue (
    .clk_i,
    .rst_ni,
    .push_i    (res_push),
    .wr_data_i (res_data),
    .full_o    (res_full),
    .pop_i     (pop && !empty),
    .rd_data_o (inside_res_o),
    .empty_o   (empty)
  );

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW         = pip_pkg::COORD_BITS_DEF;
  localparam int          HOLD_LEN   = 60;    // long receiver hold-off, in cycles
  localparam int          QUIET_MAX  = 1000;  // cycles without any handshake
  localparam int          DRAIN_PAD  = 8;
  localparam int          ITEM_GOAL  = 650;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t qx;
    coord_t qy;
    coord_t vx;
    coord_t vy;
    logic   last;
    logic   typed;   // expected result given in the row
    logic   want_in;
  } vertex_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   push;
  logic   full;
  coord_t query_x_i;
  coord_t query_y_i;
  coord_t vertex_x_i;
  coord_t vertex_y_i;
  logic   last_vertex_i;
  logic   empty;
  logic   pop;
  logic   inside_res_o;

  point_in_polygon_test DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .query_x_i    (query_x_i),
    .query_y_i    (query_y_i),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .last_vertex_i(last_vertex_i),
    .empty        (empty),
    .pop          (pop),
    .inside_res_o (inside_res_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ray casting state
  coord_t first_x, first_y, prev_x, prev_y, held_qx, held_qy;
  bit     odd_crossings;
  bit     in_polygon;
  bit     inside_expected[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_reqs;
  int vertices_sent;
  int polygons_closed;
  int results_checked;
  int inside_seen;
  int fail_cnt;
  int quiet_cycles;

  localparam int N_ROWS = 23;
  vertex_row_t directed_rows [N_ROWS] = '{
    // single-vertex polygons at the coordinate extremes
    '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 1'b0},
    '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b0},
    // two-vertex polygon: same segment twice
    '{16'sd0, 16'sd0, -16'sd100, -16'sd100, 1'b0, 1'b0, 1'b0},
    '{16'sh5A5A, 16'shA5A5, 16'sd100, 16'sd100, 1'b1, 1'b1, 1'b0},
    // small square, query at centre
    '{16'sd0, 16'sd0, -16'sd10, -16'sd10, 1'b0, 1'b0, 1'b0},
    '{16'sh7FFF, 16'sh8000, 16'sd10, -16'sd10, 1'b0, 1'b0, 1'b0},
    '{16'sh8000, 16'sh7FFF, 16'sd10, 16'sd10, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, -16'sd10, 16'sd10, 1'b1, 1'b1, 1'b1},
    // same square, query to the right
    '{16'sd20, 16'sd0, -16'sd10, -16'sd10, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd10, -16'sd10, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, -16'sd10, 16'sd10, 1'b1, 1'b1, 1'b0},
    // full-range square
    '{16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0},
    // horizontal edge on the query line
    '{16'sd0, 16'sd5, -16'sd10, 16'sd5, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd10, 16'sd5, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd20, 1'b1, 1'b0, 1'b0},
    // full-range square, query on its left edge
    '{16'sh8000, 16'sd0, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0},
    '{16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0}
  };

  // edge from (xi,yi) to (xj,yj) crosses the ray going right from the held query
  function automatic bit ray_hits_edge(coord_t xi, coord_t yi, coord_t xj, coord_t yj);
    longint dy, lhs, rhs;
    if ((yi > held_qy) == (yj > held_qy)) return 1'b0;
    dy  = longint'(yj) - longint'(yi);
    lhs = (longint'(held_qx) - longint'(xi)) * dy;
    rhs = (longint'(xj) - longint'(xi)) * (longint'(held_qy) - longint'(yi));
    return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  function automatic coord_t any_coord();
    logic [31:0] r;
    r = $urandom();
    return r[CW-1:0];
  endfunction

  function automatic coord_t coord_near(int centre, int span);
    int v;
    v = centre + int'($urandom_range(2 * span)) - span;
    return coord_t'(v);
  endfunction

  task automatic sender_gap();
    if (int'($urandom_range(99)) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while (int'($urandom_range(99)) < send_idle_pct);
    end
  endtask

  task automatic offer_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy, bit last,
                              bit typed, bit typed_inside);
    push          <= 1'b1;
    query_x_i     <= qx;
    query_y_i     <= qy;
    vertex_x_i    <= vx;
    vertex_y_i    <= vy;
    last_vertex_i <= last;
    do @(posedge clk_i); while (full);
    vertices_sent++;
    if (!in_polygon) begin
      held_qx       = qx;
      held_qy       = qy;
      first_x       = vx;
      first_y       = vy;
      odd_crossings = 1'b0;
    end else if (ray_hits_edge(vx, vy, prev_x, prev_y)) begin
      odd_crossings = !odd_crossings;
    end
    prev_x = vx;
    prev_y = vy;
    if (last) begin
      if (ray_hits_edge(first_x, first_y, vx, vy)) odd_crossings = !odd_crossings;
      inside_expected.insert(inside_expected.size(), typed ? typed_inside : odd_crossings);
      polygons_closed++;
      in_polygon = 1'b0;
    end else begin
      in_polygon = 1'b1;
    end
  endtask

  task automatic random_polygon();
    int     pick, n, span, cx, cy;
    bit     wide;
    coord_t qx, qy, vx, vy;
    pick = int'($urandom_range(99));
    if (pick < 10)      n = 1;
    else if (pick < 20) n = 2;
    else if (pick < 95) n = int'($urandom_range(3, 8));
    else                n = int'($urandom_range(9, 20));
    wide = ($urandom_range(3) == 0);
    case ($urandom_range(2))
      0:       span = 4;     // tiny window: query often level with vertices
      1:       span = 64;
      default: span = 1024;
    endcase
    cx = int'($urandom_range(2000)) - 1000;
    cy = int'($urandom_range(2000)) - 1000;
    qx = wide ? any_coord() : coord_near(cx, span / 2);
    qy = wide ? any_coord() : coord_near(cy, span / 2);
    for (int i = 0; i < n; i++) begin
      vx = wide ? any_coord() : coord_near(cx, span);
      vy = wide ? any_coord() : coord_near(cy, span);
      sender_gap();
      // query fields only matter on the opening vertex
      if (i == 0) offer_vertex(qx, qy, vx, vy, (i == n - 1), 1'b0, 1'b0);
      else offer_vertex(any_coord(), any_coord(), vx, vy, (i == n - 1), 1'b0, 1'b0);
    end
  endtask

  // result side: random stalls plus the occasional long hold-off
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (int'($urandom_range(99)) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (inside_expected.size() == 0) begin
          $error("unexpected result: inside_res_o = %0d", inside_res_o);
          fail_cnt++;
        end else begin
          bit want;
          want = inside_expected.pop_front();
          results_checked++;
          if (inside_res_o) inside_seen++;
          if (inside_res_o !== want) begin
            $error("inside_res: expected %0d, actual %0d", want, inside_res_o);
            fail_cnt++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_MAX, inside_expected.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    push            = 1'b0;
    query_x_i       = '0;
    query_y_i       = '0;
    vertex_x_i      = '0;
    vertex_y_i      = '0;
    last_vertex_i   = 1'b0;
    first_x         = '0;
    first_y         = '0;
    prev_x          = '0;
    prev_y          = '0;
    held_qx         = '0;
    held_qy         = '0;
    odd_crossings   = 1'b0;
    in_polygon      = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_reqs       = 0;
    vertices_sent   = 0;
    polygons_closed = 0;
    results_checked = 0;
    inside_seen     = 0;
    fail_cnt        = 0;
    quiet_cycles    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_vertex(directed_rows[i].qx, directed_rows[i].qy, directed_rows[i].vx,
                   directed_rows[i].vy, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].want_in);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_reqs++;  // fill the block up against a stalled result side
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      while (vertices_sent < N_ROWS + (ITEM_GOAL - N_ROWS) * (phase + 1) / 4)
        random_polygon();
    end

    push <= 1'b0;
    recv_stall_pct = 0;
    while (inside_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);

    $display("%0d vertices in %0d polygons; %0d results checked, %0d inside",
             vertices_sent, polygons_closed, results_checked, inside_seen);
    $display("stall phases: none, sender idle, receiver stall, both; one long hold-off");
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
